### rtl/core/psdv_pkg.sv
// Shared types and constants for the plucked-string delay voice.
package psdv_pkg;

	// Default sizes of the delay line.
	localparam int DEFAULT_DEPTH       = 65536;
	localparam int DEFAULT_SAMPLE_BITS = 16;

	// Widths of the stream fields and the configuration port.
	localparam int FIELD_W     = 16;
	localparam int IN_DATA_W   = 48;
	localparam int OUT_DATA_W  = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_DELAY_SAMPLES = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_GAIN = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BURST_LENGTH  = 2'd2;

	// Register values after reset.
	localparam logic [31:0] RST_DELAY_SAMPLES = 32'd3145728000;
	localparam logic [15:0] RST_FEEDBACK_GAIN = 16'd33;
	localparam logic [15:0] RST_BURST_LENGTH  = 16'd48000;

	// Q1.15 unity, rounding offset and 16-bit saturation limits.
	localparam int Q15_ONE   = 32768;
	localparam int Q15_HALF  = 16384;
	localparam int SAT16_MAX = 32767;
	localparam int SAT16_MIN = -32768;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_WAIT,
		S_CUBIC_A,
		S_CUBIC_B,
		S_CUBIC_C,
		S_FILT_A,
		S_FILT_B,
		S_WRITE
	} state_t;

	// Delay-line taps in the order they are read.
	typedef enum logic [1:0] {
		TAP_D1,
		TAP_D0,
		TAP_D2,
		TAP_D3
	} tap_t;

endpackage

### rtl/core/psdv_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module psdv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/plucked_string_delay_voice.sv
// Top level of the plucked-string delay voice.
//
// This block is one plucked-string voice of the Karplus-Strong kind. Each input item carries
// an excitation sample, a trigger level and a one-pole lowpass coefficient, all signed Q1.15,
// and produces exactly one output item, the filtered string sample. A trigger that rises from
// zero or below to above zero loads a burst counter with burst_length; while the counter runs,
// the excitation is fed into the loop, otherwise silence is. Four taps around the fractional
// delay are read from a circular delay line, interpolated with a cubic, mixed with the previous
// output by the lowpass, and the saturated result is the output. The excitation plus the output
// scaled by feedback_gain is then written back at the write pointer, so all reads of an item see
// the line as it was before that item. The delay register is unsigned Q16.16 and is clamped to
// the range of one sample to DEPTH-3 samples. The delay line sits in one RAM with a single read
// port and a single write port. An item occupies the block from the cycle in which it is
// accepted to the cycle that loads its result into the output register, and a new item is
// accepted only after the previous one has been written back. The item passes through IDLE to
// accept, READ for the four tap reads through the single read port, WAIT for the read latency,
// CUBIC_A to CUBIC_C for the three chained multiplications of the cubic, FILT_A and FILT_B for
// the lowpass and WRITE for the feedback and the write-back. If the previous result has not
// been taken yet, the block holds in WRITE until the output register frees up. No
// clearing pass follows reset: the write pointer and a wrap flag tell which entries have been
// written since reset, and an entry that has not been written reads as zero, so the block
// accepts items right after reset. Configuration writes take effect at once and should be made
// only while no item is in flight.
module plucked_string_delay_voice #(
	parameter int DEPTH       = psdv_pkg::DEFAULT_DEPTH,
	parameter int SAMPLE_BITS = psdv_pkg::DEFAULT_SAMPLE_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input stream. tdata, from bit 0 up: sample_in[15:0], trigger_level[15:0],
	// lowpass_coef[15:0].
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [psdv_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// Output stream. tdata, from bit 0 up: sample_out[15:0].
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [psdv_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// Configuration write port.
	input  logic                               cfg_wr_en,
	input  logic [psdv_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [psdv_pkg::CFG_DATA_W-1:0]    cfg_data
);

	import psdv_pkg::*;

	// Address width of the delay line.
	localparam int AW = $clog2(DEPTH);
	// Cubic accumulator: taps of SAMPLE_BITS grow by up to about 11 times during the cubic.
	localparam int ACC_W = SAMPLE_BITS + 6;
	// Interpolated value after the final halving.
	localparam int VAL_W = ACC_W - 1;
	// Product of the lowpass weight (17 bits) and the interpolated value.
	localparam int P1_W = VAL_W + 17;
	// Lowpass sum, wide enough for both products and the rounding term.
	localparam int YS_W = ((P1_W > 32) ? P1_W : 32) + 1;
	// Write-back sum before saturation to SAMPLE_BITS.
	localparam int W_W = ((SAMPLE_BITS > 18) ? SAMPLE_BITS : 18) + 1;

	localparam logic [AW-1:0]   LAST_ADDR   = AW'(DEPTH - 1);
	localparam logic [AW-1:0]   MAX_WHOLE   = AW'(DEPTH - 3);
	localparam logic [31:0]     MAX_WHOLE32 = 32'(DEPTH - 3);
	localparam logic [AW:0]     DEPTH_EXT   = (AW + 1)'(DEPTH);
	localparam logic signed [YS_W-1:0] Y_MAX = YS_W'(SAT16_MAX);
	localparam logic signed [YS_W-1:0] Y_MIN = YS_W'(SAT16_MIN);
	localparam logic signed [W_W-1:0]  W_MAX =
		W_W'((longint'(1) <<< (SAMPLE_BITS - 1)) - longint'(1));
	localparam logic signed [W_W-1:0]  W_MIN = -W_MAX - W_W'(1);

	// Configuration registers.
	logic [31:0]        delay_q;
	logic signed [15:0] fb_q;
	logic [15:0]        blen_q;

	// Voice state.
	state_t             state_q, state_d;
	tap_t               tap_q, tap_d;
	logic [AW-1:0]      wp_q;
	logic               full_q;
	logic signed [15:0] last_q;
	logic               was_pos_q;
	logic [15:0]        burst_q;

	// Item being worked on.
	logic signed [15:0] x_q;
	logic signed [15:0] c_q;
	logic [15:0]        f_q;
	logic [AW-1:0]      rd1_q;
	logic signed [SAMPLE_BITS-1:0] d0_q, d1_q, d2_q, d3_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [P1_W-1:0]  p1_q;
	logic signed [15:0]      y_q;

	// Read pipeline.
	logic               rd_vld_s1;
	tap_t               tap_s1;
	logic               hit_s1;

	// Output register.
	logic               out_vld_q;
	logic [15:0]        out_data_q;

	// Control outputs of the sequencer.
	logic               accept;
	logic               issue_rd;
	logic               out_free;
	logic               ram_we;

	// Delay line ports.
	logic [AW-1:0]            raddr;
	logic [SAMPLE_BITS-1:0]   rdata;
	logic [SAMPLE_BITS-1:0]   wdata;

	// Input fields.
	logic signed [15:0] in_sample;
	logic signed [15:0] in_trig;
	logic signed [15:0] in_coef;

	assign in_sample = s_axis_tdata[15:0];
	assign in_trig   = s_axis_tdata[31:16];
	assign in_coef   = s_axis_tdata[47:32];

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= RST_DELAY_SAMPLES;
			fb_q    <= RST_FEEDBACK_GAIN;
			blen_q  <= RST_BURST_LENGTH;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_DELAY_SAMPLES: delay_q <= cfg_data;
				REG_FEEDBACK_GAIN: fb_q    <= cfg_data[15:0];
				REG_BURST_LENGTH:  blen_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	assign out_free = !out_vld_q || m_axis_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (s_axis_tvalid) state_d = S_READ;
			S_READ:    if (tap_q == TAP_D3) state_d = S_WAIT;
			S_WAIT:    state_d = S_CUBIC_A;
			S_CUBIC_A: state_d = S_CUBIC_B;
			S_CUBIC_B: state_d = S_CUBIC_C;
			S_CUBIC_C: state_d = S_FILT_A;
			S_FILT_A:  state_d = S_FILT_B;
			S_FILT_B:  state_d = S_WRITE;
			S_WRITE:   if (out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == S_IDLE);
		accept        = s_axis_tvalid && (state_q == S_IDLE);
		issue_rd      = (state_q == S_READ);
		ram_we        = (state_q == S_WRITE) && out_free;
	end

	// Taps are read in the order d1, d0, d2, d3.
	always_comb begin
		unique case (tap_q)
			TAP_D1:  tap_d = TAP_D0;
			TAP_D0:  tap_d = TAP_D2;
			TAP_D2:  tap_d = TAP_D3;
			TAP_D3:  tap_d = TAP_D1;
			default: tap_d = TAP_D1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tap_q   <= TAP_D1;
		end else begin
			state_q <= state_d;
			if (accept) begin
				tap_q <= TAP_D1;
			end else if (issue_rd) begin
				tap_q <= tap_d;
			end
		end
	end

	// ------------------------------------------------------------------
	// Acceptance: trigger edge, burst counter and delay clamp.
	// ------------------------------------------------------------------
	logic               trig_pos;
	logic [15:0]        burst_now;
	logic [15:0]        whole_raw;
	logic [AW-1:0]      whole;
	logic [15:0]        frac;
	logic [AW:0]        rd_diff;
	logic [AW:0]        rd_wrap;

	always_comb begin
		trig_pos  = !in_trig[15] && (in_trig != 16'sd0);
		burst_now = (trig_pos && !was_pos_q) ? blen_q : burst_q;

		whole_raw = delay_q[31:16];
		if (whole_raw == 16'd0) begin
			whole = AW'(1);
			frac  = 16'd0;
		end else if ({16'd0, whole_raw} >= MAX_WHOLE32) begin
			// At or beyond the top of the range the delay sits exactly at DEPTH-3.
			whole = MAX_WHOLE;
			frac  = 16'd0;
		end else begin
			whole = AW'(whole_raw);
			frac  = delay_q[15:0];
		end

		rd_diff = {1'b0, wp_q} - {1'b0, whole};
		rd_wrap = rd_diff + DEPTH_EXT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_pos_q <= 1'b0;
			burst_q   <= 16'd0;
		end else if (accept) begin
			was_pos_q <= trig_pos;
			burst_q   <= (burst_now == 16'd0) ? 16'd0 : burst_now - 16'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= (burst_now == 16'd0) ? 16'sd0 : in_sample;
			c_q   <= in_coef;
			f_q   <= frac;
			rd1_q <= rd_diff[AW] ? rd_wrap[AW-1:0] : rd_diff[AW-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Tap reads. An entry not written since reset reads as zero.
	// ------------------------------------------------------------------
	always_comb begin
		case (tap_q)
			TAP_D1:  raddr = rd1_q;
			TAP_D0:  raddr = (rd1_q == LAST_ADDR) ? '0 : rd1_q + AW'(1);
			TAP_D2:  raddr = (rd1_q == '0) ? LAST_ADDR : rd1_q - AW'(1);
			TAP_D3:  raddr = (rd1_q < AW'(2)) ? rd1_q + AW'(DEPTH - 2) : rd1_q - AW'(2);
			default: raddr = rd1_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue_rd;
		end
	end

	always_ff @(posedge clk) begin
		tap_s1 <= tap_q;
		hit_s1 <= full_q || (raddr < wp_q);
		if (rd_vld_s1) begin
			case (tap_s1)
				TAP_D1:  d1_q <= hit_s1 ? rdata : '0;
				TAP_D0:  d0_q <= hit_s1 ? rdata : '0;
				TAP_D2:  d2_q <= hit_s1 ? rdata : '0;
				TAP_D3:  d3_q <= hit_s1 ? rdata : '0;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Cubic interpolation: one shared multiplier by the fraction, three passes.
	// ------------------------------------------------------------------
	logic signed [ACC_W-1:0]    e0, e1, e2, e3;
	logic signed [ACC_W-1:0]    a2, b2, c2;
	logic signed [ACC_W-1:0]    mul_op;
	logic signed [ACC_W-1:0]    mul_add;
	logic signed [ACC_W+16:0]   mul_prod;

	always_comb begin
		e0 = ACC_W'(d0_q);
		e1 = ACC_W'(d1_q);
		e2 = ACC_W'(d2_q);
		e3 = ACC_W'(d3_q);
		// Doubled polynomial coefficients.
		a2 = (e3 - e0) + (e1 - e2) + ((e1 - e2) <<< 1);
		b2 = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
		c2 = e2 - e0;

		case (state_q)
			S_CUBIC_A: begin
				mul_op  = a2;
				mul_add = b2;
			end
			S_CUBIC_B: begin
				mul_op  = acc_q;
				mul_add = c2;
			end
			default: begin
				mul_op  = acc_q;
				mul_add = e1 <<< 1;
			end
		endcase
		mul_prod = mul_op * $signed({1'b0, f_q});
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_CUBIC_A) || (state_q == S_CUBIC_B) || (state_q == S_CUBIC_C)) begin
			// The arithmetic shift by 16 floors toward minus infinity.
			acc_q <= $signed(mul_prod[ACC_W+15:16]) + mul_add;
		end
	end

	// ------------------------------------------------------------------
	// One-pole lowpass against the previous output.
	// ------------------------------------------------------------------
	logic signed [ACC_W-1:0]  val_sum;
	logic signed [VAL_W-1:0]  value;
	logic signed [16:0]       c_ext;
	logic signed [16:0]       abs_c;
	logic signed [16:0]       weight;
	logic signed [31:0]       c_last;
	logic signed [YS_W-1:0]   y_sum;
	logic signed [YS_W-1:0]   y_shift;
	logic signed [15:0]       y_sat;

	always_comb begin
		// Halve the doubled result with rounding half up.
		val_sum = acc_q + ACC_W'(1);
		value   = $signed(val_sum[ACC_W-1:1]);
		c_ext   = 17'(c_q);
		abs_c   = c_ext[16] ? -c_ext : c_ext;
		weight  = 17'(Q15_ONE) - abs_c;

		c_last  = c_q * last_q;
		y_sum   = YS_W'(p1_q) + YS_W'(c_last) + YS_W'(Q15_HALF);
		y_shift = y_sum >>> 15;
		if (y_shift > Y_MAX) begin
			y_sat = 16'(SAT16_MAX);
		end else if (y_shift < Y_MIN) begin
			y_sat = 16'(SAT16_MIN);
		end else begin
			y_sat = y_shift[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FILT_A) begin
			p1_q <= P1_W'(weight) * P1_W'(value);
		end
		if (state_q == S_FILT_B) begin
			y_q <= y_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 16'sd0;
		end else if (state_q == S_FILT_B) begin
			last_q <= y_sat;
		end
	end

	// ------------------------------------------------------------------
	// Feedback and write-back.
	// ------------------------------------------------------------------
	logic signed [31:0]      fb_prod;
	logic signed [32:0]      fb_round;
	logic signed [W_W-1:0]   w_sum;

	always_comb begin
		fb_prod  = fb_q * y_q;
		fb_round = 33'(fb_prod) + 33'(Q15_HALF);
		w_sum    = W_W'($signed(fb_round[32:15])) + W_W'(x_q);
		if (w_sum > W_MAX) begin
			wdata = W_MAX[SAMPLE_BITS-1:0];
		end else if (w_sum < W_MIN) begin
			wdata = W_MIN[SAMPLE_BITS-1:0];
		end else begin
			wdata = w_sum[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			full_q <= 1'b0;
		end else if (ram_we) begin
			if (wp_q == LAST_ADDR) begin
				wp_q   <= '0;
				full_q <= 1'b1;
			end else begin
				wp_q <= wp_q + AW'(1);
			end
		end
	end

	psdv_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (DEPTH)
	) u_delay_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ram_we) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			out_data_q <= y_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

endmodule

### verif/plucked_string_delay_voice_tb.sv
// Self-checking testbench for the plucked-string delay voice.
module plucked_string_delay_voice_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import psdv_pkg::*;

	// The delay line of the predictor matches the block's default size.
	localparam int LINE_DEPTH = DEFAULT_DEPTH;
	// Longest delay the block uses, in Q16.16.
	localparam longint LONGEST_DELAY = longint'(LINE_DEPTH - 3) << 16;
	// Index with no register behind it; writes to it must be ignored.
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;
	// Number of clock cycles one item occupies the block.
	localparam int ITEM_CYCLES = 12;
	// Cycles without any accepted item before the run is declared hung.
	localparam int HANG_LIMIT = 2000;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       s_axis_tvalid;
	logic                       s_axis_tready;
	// tdata, from bit 0 up: sample_in[15:0], trigger_level[15:0], lowpass_coef[15:0].
	logic [IN_DATA_W-1:0]       s_axis_tdata;
	logic                       m_axis_tvalid;
	logic                       m_axis_tready = 1'b1;
	// tdata, from bit 0 up: sample_out[15:0].
	logic [OUT_DATA_W-1:0]      m_axis_tdata;
	logic                       cfg_wr_en;
	logic [CFG_INDEX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;

	plucked_string_delay_voice dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 20 ns clock period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// String model: its own copy of the delay line, the loop state and the
	// three registers. It is advanced once per accepted item.
	// ------------------------------------------------------------------
	shortint        string_line [LINE_DEPTH];
	int             line_wr_ptr;
	longint         prev_output;
	bit             trigger_high;
	logic [15:0]    excite_left;
	logic [31:0]    delay_reg;
	longint         loop_gain;
	logic [15:0]    excite_len;

	// Output samples still owed by the block, oldest first.
	logic [15:0]    owed_samples [$];
	int             mismatch_count;
	int             items_played;

	// Sender burst shaping: items left in the current burst, and whether
	// gaps between bursts are suppressed.
	int             send_burst_left;
	bit             send_gapless;

	// Receiver stall pattern, rotated one bit per cycle.
	logic [15:0]    ready_pattern = 16'hFFFF;
	int             pattern_age;
	int             quiet_cycles;

	function automatic longint sat16(input longint v);
		if (v > SAT16_MAX)
			return SAT16_MAX;
		if (v < SAT16_MIN)
			return SAT16_MIN;
		return v;
	endfunction

	// Works out the output of one item and updates the string state.
	function automatic logic [15:0] pluck_predict(input logic [15:0] smp,
			input logic [15:0] trg, input logic [15:0] coef);
		longint excite, c, dly, frac, t0, t1, t2, t3, acc, value, abs_c, y, fed;
		int     whole, tap1;
		excite = longint'($signed(smp));
		c      = longint'($signed(coef));

		// A rising trigger reloads the excitation counter, even mid-burst.
		if ($signed(trg) > 0 && !trigger_high)
			excite_left = excite_len;
		trigger_high = $signed(trg) > 0;
		if (excite_left == 16'd0)
			excite = 0;
		else
			excite_left = excite_left - 16'd1;

		// Clamp the delay to one sample up to DEPTH-3 samples.
		dly = delay_reg;
		if (dly < 65536)
			dly = 65536;
		if (dly > LONGEST_DELAY)
			dly = LONGEST_DELAY;
		whole = int'(dly >> 16);
		frac  = dly & 64'hFFFF;

		// All taps see the line before this item's write.
		tap1 = (line_wr_ptr + LINE_DEPTH - whole) % LINE_DEPTH;
		t1 = string_line[tap1];
		t0 = string_line[(tap1 + 1) % LINE_DEPTH];
		t2 = string_line[(tap1 + LINE_DEPTH - 1) % LINE_DEPTH];
		t3 = string_line[(tap1 + LINE_DEPTH - 2) % LINE_DEPTH];

		// Cubic with doubled coefficients, floored at every step.
		acc = (t3 - t0) + 3 * (t1 - t2);
		acc = (acc * frac) >>> 16;
		acc = acc + 2 * t0 - 5 * t1 + 4 * t2 - t3;
		acc = (acc * frac) >>> 16;
		acc = acc + t2 - t0;
		acc = (acc * frac) >>> 16;
		value = (acc + 2 * t1 + 1) >>> 1;

		// One-pole lowpass against the previous output.
		abs_c = (c < 0) ? -c : c;
		y = sat16(((Q15_ONE - abs_c) * value + c * prev_output + Q15_HALF) >>> 15);

		fed = excite + ((loop_gain * y + Q15_HALF) >>> 15);
		string_line[line_wr_ptr] = shortint'(sat16(fed));
		prev_output = y;
		line_wr_ptr = (line_wr_ptr + 1) % LINE_DEPTH;
		return y[15:0];
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers. Every task starts and ends on a falling edge.
	// ------------------------------------------------------------------

	// Writes one register and mirrors the write in the model.
	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
		case (idx)
			REG_DELAY_SAMPLES: delay_reg = value;
			REG_FEEDBACK_GAIN: loop_gain = longint'($signed(value[15:0]));
			REG_BURST_LENGTH:  excite_len = value[15:0];
			default: ;
		endcase
	endtask

	// Offers one item, in bursts with random gaps, and records its output.
	task automatic play_sample(input logic [15:0] smp, input logic [15:0] trg,
			input logic [15:0] coef);
		if (send_burst_left == 0) begin
			if (!send_gapless) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
			send_burst_left = $urandom_range(1, 12);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {coef, trg, smp};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		owed_samples.push_back(pluck_predict(smp, trg, coef));
		items_played++;
		send_burst_left--;
		@(negedge clk);
	endtask

	// Stops sending, waits for every owed output and lets the block settle,
	// so that registers may be written.
	task automatic drain_voice();
		s_axis_tvalid <= 1'b0;
		send_burst_left = 0;
		while (owed_samples.size() != 0)
			@(posedge clk);
		repeat (ITEM_CYCLES + 4) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Directed tests.
	// ------------------------------------------------------------------

	// Register values straight after reset: the 48000-sample delay reads
	// only unwritten entries, which read as zero, and the coefficient extremes are applied.
	task automatic test_after_reset();
		play_sample(16'h7FFF, 16'h0001, 16'h0000);
		play_sample(16'h8000, 16'h7FFF, 16'h8000);
		play_sample(16'h0000, 16'h8000, 16'h7FFF);
		play_sample(16'h5555, 16'h0000, 16'hAAAA);
		drain_voice();
	endtask

	// Delay below one sample is clamped to one: the newest tap reads the
	// word about to be overwritten. Gain at its positive limit, full-scale
	// excitation, and an item past the end of the burst.
	task automatic test_unit_delay();
		write_register(REG_DELAY_SAMPLES, 32'h0000_0000);
		write_register(REG_FEEDBACK_GAIN, 32'h0000_7FFF);
		write_register(REG_BURST_LENGTH, 32'd3);
		play_sample(16'h7FFF, 16'h0000, 16'h0000);
		play_sample(16'h8000, 16'h0040, 16'h7FFF);
		play_sample(16'h3039, 16'h0040, 16'h8000);
		play_sample(16'h7FFF, 16'h0040, 16'hFFFF);
		play_sample(16'h1234, 16'h0040, 16'h4000);
		drain_voice();
	endtask

	// Fractional delay of 2.5 samples, gain at its negative limit, and a
	// trigger that drops and rises again to load the counter for a burst.
	task automatic test_fractional_retrigger();
		write_register(REG_DELAY_SAMPLES, 32'h0002_8000);
		write_register(REG_FEEDBACK_GAIN, 32'h0000_8000);
		write_register(REG_BURST_LENGTH, 32'd2);
		play_sample(16'h4E20, 16'h0100, 16'h0000);
		play_sample(16'hB1E0, 16'h0000, 16'h8000);
		play_sample(16'h7FFF, 16'h0005, 16'h2000);
		play_sample(16'h8000, 16'h0005, 16'hE000);
		play_sample(16'h03E8, 16'h0005, 16'h0000);
		drain_voice();
	endtask

	// Delay beyond DEPTH-3 is clamped to DEPTH-3, a zero burst
	// length makes a trigger inject nothing, and the unmapped index does
	// not disturb any register.
	task automatic test_long_delay_no_burst();
		write_register(REG_DELAY_SAMPLES, 32'hFFFF_FFFF);
		write_register(REG_BURST_LENGTH, 32'd0);
		write_register(REG_UNMAPPED, 32'hFFFF_FFFF);
		play_sample(16'h8000, 16'h8000, 16'h0000);
		play_sample(16'h7FFF, 16'h0001, 16'h1000);
		play_sample(16'h7FFF, 16'h0001, 16'h0000);
		drain_voice();
	endtask

	// ------------------------------------------------------------------
	// Random plucks: each phase picks a new setting, then plays a pluck
	// with random excitation so the loop rings and decays.
	// ------------------------------------------------------------------
	task automatic test_random_plucks();
		logic [31:0] dly;
		logic [15:0] gain, blen, trg, coef;
		bit          level_high;
		int          phase_len;
		while (items_played < 600) begin
			case ($urandom_range(0, 9))
				0: dly = $urandom;
				1: case ($urandom_range(0, 4))
					0: dly = 32'h0000_0000;
					1: dly = 32'hFFFF_FFFF;
					2: dly = 32'h0001_0000;
					3: dly = 32'h0001_FFFF;
					default: dly = 32'(LONGEST_DELAY);
				endcase
				default: dly = (32'($urandom_range(1, 40)) << 16)
						| ($urandom_range(0, 1) ? 32'($urandom_range(0, 65535)) : 32'd0);
			endcase
			case ($urandom_range(0, 7))
				0: gain = 16'h8000;
				1: gain = 16'h7FFF;
				2: gain = 16'($urandom);
				3: gain = 16'h0000;
				default: gain = $urandom_range(0, 1) ? 16'($urandom_range(26000, 32767))
						: 16'(0 - $urandom_range(26000, 32768));
			endcase
			case ($urandom_range(0, 7))
				0: blen = 16'd0;
				1: blen = 16'hFFFF;
				2: blen = 16'($urandom);
				default: blen = 16'($urandom_range(1, 60));
			endcase
			write_register(REG_DELAY_SAMPLES, dly);
			write_register(REG_FEEDBACK_GAIN, {16'h0000, gain});
			write_register(REG_BURST_LENGTH, {16'h0000, blen});
			if ($urandom_range(0, 3) == 0)
				write_register(REG_UNMAPPED, $urandom);

			send_gapless = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(30, 80);
			// Start low so the phase opens with a clean rising trigger.
			level_high = 1'b0;
			for (int n = 0; n < phase_len; n++) begin
				if (n == 1 || $urandom_range(0, 15) == 0)
					level_high = !level_high;
				if ($urandom_range(0, 9) == 0)
					trg = 16'($urandom);
				else if (level_high)
					trg = 16'($urandom_range(1, 32767));
				else
					trg = 16'(0 - $urandom_range(0, 32768));
				case ($urandom_range(0, 15))
					0: coef = 16'h8000;
					1: coef = 16'h7FFF;
					2, 3, 4, 5: coef = 16'($urandom);
					default: coef = 16'($urandom_range(0, 24000));
				endcase
				play_sample(16'($urandom), trg, coef);
			end
			drain_voice();
			send_gapless = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver: tready follows a 16-bit pattern that is rotated every
	// cycle and replaced now and then by an all-ready, random, dense or sparse one.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (pattern_age <= 0) begin
			case ($urandom_range(0, 3))
				0: ready_pattern <= 16'hFFFF;
				1: ready_pattern <= 16'($urandom);
				2: ready_pattern <= 16'($urandom & $urandom);
				default: ready_pattern <= 16'($urandom | $urandom);
			endcase
			pattern_age <= $urandom_range(40, 160);
		end else begin
			ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
			pattern_age <= pattern_age - 1;
		end
		m_axis_tready <= ready_pattern[0];
	end

	// Every accepted output is checked against the oldest owed sample.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
			if (owed_samples.size() == 0) begin
				$error("sample_out: no item expected, got %0d", $signed(m_axis_tdata));
				mismatch_count++;
			end else if (m_axis_tdata !== owed_samples[0]) begin
				$error("sample_out: expected %0d, got %0d", $signed(owed_samples[0]),
					$signed(m_axis_tdata));
				mismatch_count++;
				void'(owed_samples.pop_front());
			end else begin
				void'(owed_samples.pop_front());
			end
		end
	end

	// Hang detection: any accepted item on either stream restarts the count.
	always @(posedge clk) begin
		if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1)
				|| (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		s_axis_tvalid   = 1'b0;
		s_axis_tdata    = '0;
		cfg_wr_en       = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		pattern_age     = 0;
		quiet_cycles    = 0;
		mismatch_count  = 0;
		items_played    = 0;
		send_burst_left = 0;
		send_gapless    = 1'b0;
		line_wr_ptr     = 0;
		prev_output     = 0;
		trigger_high    = 1'b0;
		excite_left     = 16'd0;
		delay_reg       = RST_DELAY_SAMPLES;
		loop_gain       = longint'($signed(RST_FEEDBACK_GAIN));
		excite_len      = RST_BURST_LENGTH;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_after_reset();
		test_unit_delay();
		test_fractional_retrigger();
		test_long_delay_no_burst();
		test_random_plucks();

		// Everything has been accepted and returned; watch a while longer
		// for stray outputs before the verdict.
		drain_voice();
		repeat (3 * ITEM_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### sim.f
rtl/core/psdv_pkg.sv
rtl/core/psdv_ram.sv
rtl/core/plucked_string_delay_voice.sv
verif/plucked_string_delay_voice_tb.sv
